FILE: rtl/acp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types, constants and helpers for the automation curve player.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int MAX_CHUNKS_D       = 8;
    localparam int CHUNK_BEATS_D      = 32;
    localparam int SAMPLES_PER_BEAT_D = 256;
    localparam int LEVEL_BITS_D       = 16;

    localparam logic [0:0] CMD_TICK = 1'b0;
    localparam logic [0:0] CMD_RAMP = 1'b1;

    localparam logic [2:0] REG_SYNC_MODE  = 3'd0;
    localparam logic [2:0] REG_LOOP_ON    = 3'd1;
    localparam logic [2:0] REG_PHASE_STEP = 3'd2;
    localparam logic [2:0] REG_DUR_SEL    = 3'd3;
    localparam logic [2:0] REG_CUSTOM     = 3'd4;

    localparam logic [2:0] DUR_CUSTOM = 3'd0;
    localparam logic [2:0] DUR_4      = 3'd1;
    localparam logic [2:0] DUR_16     = 3'd2;
    localparam logic [2:0] DUR_32     = 3'd3;
    localparam logic [2:0] DUR_64     = 3'd4;
    localparam logic [2:0] DUR_128    = 3'd5;

    typedef struct packed {
        logic [0:0]         cmd;
        logic signed [31:0] song_beat;
        logic [2:0]         chunk_number;
        logic [12:0]        first_index;
        logic [12:0]        final_index;
        logic [15:0]        first_level;
        logic [15:0]        final_level;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        level;
        logic [15:0]        inverted_level;
        logic signed [15:0] bipolar_level;
        logic [19:0]        pitch_volts;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_IDX, ST_RD, ST_RD2, ST_OUT,
        ST_RSETUP, ST_RMUL, ST_RDIV, ST_RWR
    } t_state;

    function automatic logic [8:0] dur_beats(input logic [2:0] sel, input logic [8:0] cust);
        logic [8:0] r;
        r = 9'd32;
        case (sel)
            DUR_CUSTOM: begin
                if (cust < 9'd4) r = 9'd4;
                else if (cust > 9'd256) r = 9'd256;
                else r = cust;
            end
            DUR_4:   r = 9'd4;
            DUR_16:  r = 9'd16;
            DUR_32:  r = 9'd32;
            DUR_64:  r = 9'd64;
            DUR_128: r = 9'd128;
            default: r = 9'd32;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/automation_curve_player_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// automation_curve_player_unit
// Ticks: index, read and output states, after an iterative modulo in sync mode
// with loop on. Ramps: a setup state, then per written sample a multiply, an
// iterative divide and a write. A two-entry queue buffers the input; one item
// is finished before the next is taken, and a waiting result holds the engine
// in its output stage. Reset: a clearing pass fills all MAX_CHUNKS*CHUNK_BEATS*
// SAMPLES_PER_BEAT (65536 by default) store entries with 0.5 before items are taken.
// ----------------------------------------------------------------------------
module automation_curve_player_unit
    import acp_pkg::*;
#(
    parameter int MAX_CHUNKS       = MAX_CHUNKS_D,
    parameter int CHUNK_BEATS      = CHUNK_BEATS_D,
    parameter int SAMPLES_PER_BEAT = SAMPLES_PER_BEAT_D
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  wire        i_stall,
    output t_out_item  o_data,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data
);
    logic        r_sync, r_loop;
    logic [31:0] r_step;
    logic [2:0]  r_dsel;
    logic [8:0]  r_cust;
    logic        w_qv, w_take;
    t_in_item    w_qd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= 1'b1;
            r_loop <= 1'b1;
            r_step <= 32'd89478;
            r_dsel <= DUR_CUSTOM;
            r_cust <= 9'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC_MODE:  r_sync <= i_cfg_data[0];
                REG_LOOP_ON:    r_loop <= i_cfg_data[0];
                REG_PHASE_STEP: r_step <= i_cfg_data;
                REG_DUR_SEL:    r_dsel <= i_cfg_data[2:0];
                REG_CUSTOM:     r_cust <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    acp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(w_qv), .i_take(w_take), .o_data(w_qd)
    );

    acp_back #(
        .MAX_CHUNKS(MAX_CHUNKS), .CHUNK_BEATS(CHUNK_BEATS),
        .SAMPLES_PER_BEAT(SAMPLES_PER_BEAT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_take(w_take),
        .i_data(w_qd), .i_sync_mode(r_sync), .i_loop_on(r_loop),
        .i_phase_step(r_step), .i_dur_sel(r_dsel), .i_custom(r_cust),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule
`default_nettype wire

FILE: rtl/acp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module acp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/acp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_front
// Input register queue: two-entry FIFO between the port and the engine.
// ----------------------------------------------------------------------------
module acp_front
    import acp_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  wire       i_take,
    output t_in_item  o_data
);
    t_in_item   r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_q[r_wp] <= i_data;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue overflow");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop when empty");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd1) |-> (r_wp == r_rp)) else $error("pointer mismatch");
endmodule
`default_nettype wire

FILE: rtl/acp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_back
// Execution engine: tick lookup with iterative modulo, ramp writer with
// iterative divide, curve store and output register.
// ----------------------------------------------------------------------------
module acp_back
    import acp_pkg::*;
#(
    parameter int MAX_CHUNKS       = MAX_CHUNKS_D,
    parameter int CHUNK_BEATS      = CHUNK_BEATS_D,
    parameter int SAMPLES_PER_BEAT = SAMPLES_PER_BEAT_D
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_take,
    input  t_in_item   i_data,
    input  wire        i_sync_mode,
    input  wire        i_loop_on,
    input  wire [31:0] i_phase_step,
    input  wire [2:0]  i_dur_sel,
    input  wire [8:0]  i_custom,
    output logic       o_valid,
    input  wire        i_stall,
    output t_out_item  o_data
);
    localparam int CS    = CHUNK_BEATS * SAMPLES_PER_BEAT;
    localparam int DEPTH = MAX_CHUNKS * CS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [15:0] HALF = 16'h8000;

    t_state r_st, n_st;
    t_in_item r_it;
    logic [31:0] r_phase;
    logic [AW:0] r_clr;
    logic [MAX_CHUNKS-1:0] r_cv;
    logic [32:0] r_mag;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [48:0] r_idx;
    logic        r_miss;
    logic [12:0] r_i;
    logic signed [30:0] r_num;
    logic [15:0] r_q;
    logic [13:0] r_r;
    logic [31:0] r_dn;
    logic [15:0] r_lv;
    logic        r_ov;
    t_out_item   r_out;

    logic [8:0]  w_dur;
    logic [24:0] w_dmod;
    logic [20:0] w_dspb;
    logic [52:0] w_fprod;
    logic [32:0] w_sm;
    logic [32:0] w_sh;
    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [15:0] w_wd, w_rd;
    logic [30:0] w_amag;
    logic [16:0] w_diff;
    logic [12:0] w_off;
    logic [12:0] w_den;
    logic [13:0] w_den2;
    logic [14:0] w_rsh;
    logic        w_qbit;
    logic [31:0] w_pnext;
    logic        w_hit;
    logic        w_rbad;
    logic        w_adv;

    assign w_dur   = dur_beats(i_dur_sel, i_custom);
    assign w_dmod  = {w_dur, 16'd0};
    assign w_dspb  = 21'(w_dur * SAMPLES_PER_BEAT);
    assign w_fprod = 53'(r_phase) * 53'(w_dspb);
    assign w_sm    = i_loop_on ? r_rem : r_mag;
    assign w_sh    = {r_rem[31:0], r_mag[32]};
    assign w_pnext = r_phase + i_phase_step;
    assign w_amag  = r_num[30] ? 31'(-r_num) : 31'(r_num);
    assign w_diff  = {1'b0, r_it.final_level} - {1'b0, r_it.first_level};
    assign w_off   = r_i - r_it.first_index;
    assign w_den   = r_it.final_index - r_it.first_index;
    assign w_den2  = {w_den, 1'b0};
    assign w_rsh   = {r_r, r_dn[31]};
    assign w_qbit  = (w_rsh >= {1'b0, w_den2});
    assign w_rbad  = (32'(r_it.chunk_number) >= MAX_CHUNKS)
                     || (32'(r_it.first_index) >= CS) || (32'(r_it.final_index) >= CS)
                     || (r_it.first_index > r_it.final_index);
    assign w_adv   = (r_st == ST_OUT) && (!r_ov || !i_stall);

    always_comb begin
        w_hit = 1'b0;
        for (int c = 0; c < MAX_CHUNKS; c++) begin
            if (r_idx >= 49'(c * CS) && r_idx < 49'((c + 1) * CS)) w_hit = r_cv[c];
        end
    end

    acp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLEAR: if (r_clr == (AW+1)'(DEPTH - 1)) n_st = ST_IDLE;
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_data.cmd == CMD_RAMP) n_st = ST_RSETUP;
                    else if (i_sync_mode && i_loop_on) n_st = ST_DIV;
                    else n_st = ST_IDX;
                end
            end
            ST_DIV:    if (r_cnt == 6'd0) n_st = ST_IDX;
            ST_IDX:    n_st = ST_RD;
            ST_RD:     n_st = ST_RD2;
            ST_RD2:    n_st = ST_OUT;
            ST_OUT:    if (w_adv) n_st = ST_IDLE;
            ST_RSETUP: n_st = w_rbad ? ST_IDLE : ST_RMUL;
            ST_RMUL:   n_st = ST_RDIV;
            ST_RDIV:   if (r_cnt == 6'd0) n_st = ST_RWR;
            ST_RWR:    n_st = (r_i == r_it.final_index) ? ST_IDLE : ST_RMUL;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_take = (r_st == ST_IDLE) && i_valid;
        w_we   = 1'b0;
        w_wd   = HALF;
        w_addr = r_idx[AW-1:0];
        unique case (r_st)
            ST_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_clr[AW-1:0];
            end
            ST_RWR: begin
                w_we   = 1'b1;
                w_addr = AW'(AW'(r_it.chunk_number) * AW'(CS) + AW'(r_i));
                if (r_it.first_index == r_it.final_index) w_wd = r_it.final_level;
                else if (r_num[30]) w_wd = r_it.first_level - r_q;
                else w_wd = r_it.first_level + r_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLEAR;
            r_clr   <= '0;
            r_phase <= '0;
            r_cv    <= MAX_CHUNKS'(1);
            r_ov    <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_adv) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            if (o_take && i_data.cmd == CMD_TICK && !i_sync_mode) r_phase <= w_pnext;
            if (o_take && i_data.cmd == CMD_RAMP && 32'(i_data.chunk_number) < MAX_CHUNKS)
                r_cv[CW'(i_data.chunk_number)] <= 1'b1;
        end
        if (o_take) begin
            r_it  <= i_data;
            r_neg <= i_data.song_beat[31];
            r_mag <= i_data.song_beat[31] ? 33'(-{1'b1, i_data.song_beat})
                                          : {1'b0, i_data.song_beat};
            r_rem <= '0;
            r_cnt <= 6'd32;
        end
        unique case (r_st)
            ST_DIV: begin
                r_rem <= (w_sh >= 33'(w_dmod)) ? w_sh - 33'(w_dmod) : w_sh;
                r_mag <= {r_mag[31:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_IDX: begin
                if (i_sync_mode) begin
                    if (w_sm == 33'd0) r_neg <= 1'b0;
                    r_idx <= 49'((49'(w_sm) * 49'(SAMPLES_PER_BEAT)) >> 16);
                end else begin
                    r_neg <= 1'b0;
                    r_idx <= 49'(w_fprod >> 32);
                end
            end
            ST_RD: begin
                r_miss <= r_neg || (r_idx >= 49'(DEPTH)) || !w_hit;
            end
            ST_RD2: r_lv <= r_miss ? HALF : w_rd;
            ST_OUT: begin
                if (w_adv) begin
                    r_out.level          <= r_lv;
                    r_out.inverted_level <= 16'hFFFF - r_lv;
                    r_out.bipolar_level  <= r_lv - HALF;
                    r_out.pitch_volts    <= {1'b0, r_lv, 3'd0} + {3'd0, r_lv, 1'b0};
                end
            end
            ST_RSETUP: r_i <= r_it.first_index;
            ST_RMUL: begin
                r_num <= {{14{w_diff[16]}}, w_diff} * {18'd0, w_off};
                r_cnt <= 6'd32;
            end
            ST_RDIV: begin
                if (r_cnt == 6'd32) begin
                    r_dn <= {w_amag, 1'b0} + 32'(w_den);
                    r_r  <= '0;
                    r_q  <= '0;
                end else begin
                    r_r  <= w_qbit ? 14'(w_rsh - {1'b0, w_den2}) : w_rsh[13:0];
                    r_q  <= {r_q[14:0], w_qbit};
                    r_dn <= {r_dn[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            ST_RWR: r_i <= r_i + 13'd1;
            default: ;
        endcase
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CLEAR) |-> !o_take) else $error("take during clear");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov) else $error("result lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> $stable(r_out)) else $error("stalled result changed");
    a_c0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv[0]) else $error("chunk zero invalid");
endmodule
`default_nettype wire
